// ----- hw/rtl/dwsb_pkg.sv -----
// ----------------------------------------------------------------------------
// dwsb_pkg
// Shared widths, register indexes, reset values and types for the dual wheel
// speed balancer.
// ----------------------------------------------------------------------------
package dwsb_pkg;

  // field and datapath widths
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned DUTY_BITS  = 8;
  localparam int unsigned GAIN_BITS  = 4;
  localparam int unsigned STEP_BITS  = 4;
  localparam int unsigned TGT_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 8;

  // correction product and signed accumulator widths
  localparam int unsigned CORR_BITS = COUNT_BITS + GAIN_BITS;
  localparam int unsigned ACC_BITS  =
    ((CORR_BITS > DUTY_BITS) ? CORR_BITS : DUTY_BITS) + 3;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CfgTargetCount    = 3'd0,
    CfgPwmStep        = 3'd1,
    CfgBoostAmount    = 3'd2,
    CfgBoostThreshold = 3'd3,
    CfgDiffThreshold  = 3'd4,
    CfgBalanceGain    = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [TGT_BITS-1:0]  TargetCountRst    = 8'd0;
  localparam logic [STEP_BITS-1:0] PwmStepRst        = 4'd3;
  localparam logic [STEP_BITS-1:0] BoostAmountRst    = 4'd1;
  localparam logic [TGT_BITS-1:0]  BoostThresholdRst = 8'd12;
  localparam logic [TGT_BITS-1:0]  DiffThresholdRst  = 8'd1;
  localparam logic [GAIN_BITS-1:0] BalanceGainRst    = 4'd1;

  typedef struct packed {
    logic [TGT_BITS-1:0]  target_count;
    logic [STEP_BITS-1:0] pwm_step;
    logic [STEP_BITS-1:0] boost_amount;
    logic [TGT_BITS-1:0]  boost_threshold;
    logic [TGT_BITS-1:0]  diff_threshold;
    logic [GAIN_BITS-1:0] balance_gain;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] left_duty;
    logic [DUTY_BITS-1:0] right_duty;
    logic                 idle_forced;
  } res_t;

endpackage

// ----- hw/rtl/dwsb_in_if.sv -----
// ----------------------------------------------------------------------------
// dwsb_in_if
// Input channel: one beat carries the running left and right encoder counts.
// ----------------------------------------------------------------------------
interface dwsb_in_if;
  logic                             valid;
  logic                             ready;
  logic [dwsb_pkg::COUNT_BITS-1:0]  left_count;
  logic [dwsb_pkg::COUNT_BITS-1:0]  right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

// ----- hw/rtl/dwsb_out_if.sv -----
// ----------------------------------------------------------------------------
// dwsb_out_if
// Output channel: one beat carries both new duties and the idle flag.
// ----------------------------------------------------------------------------
interface dwsb_out_if;
  logic                            valid;
  logic                            ready;
  logic [dwsb_pkg::DUTY_BITS-1:0]  left_duty;
  logic [dwsb_pkg::DUTY_BITS-1:0]  right_duty;
  logic                            idle_forced;

  modport source (output valid, output left_duty, output right_duty,
                  output idle_forced, input ready);
  modport sink   (input valid, input left_duty, input right_duty,
                  input idle_forced, output ready);
endinterface

// ----- hw/rtl/dwsb_core.sv -----
// ----------------------------------------------------------------------------
// dwsb_core
// Combinational update step: deltas, step toward target, boost, balancing
// correction, saturation and the idle rule.
// ----------------------------------------------------------------------------
module dwsb_core (
  input  dwsb_pkg::cfg_t                   cfg_i,
  input  logic [dwsb_pkg::COUNT_BITS-1:0]  left_count_i,
  input  logic [dwsb_pkg::COUNT_BITS-1:0]  right_count_i,
  input  logic [dwsb_pkg::COUNT_BITS-1:0]  last_left_i,
  input  logic [dwsb_pkg::COUNT_BITS-1:0]  last_right_i,
  input  logic [dwsb_pkg::DUTY_BITS-1:0]   left_duty_i,
  input  logic [dwsb_pkg::DUTY_BITS-1:0]   right_duty_i,
  output dwsb_pkg::res_t                   res_o
);

  localparam int unsigned CB = dwsb_pkg::COUNT_BITS;
  localparam int unsigned DB = dwsb_pkg::DUTY_BITS;
  localparam int unsigned CW = dwsb_pkg::CORR_BITS;
  localparam int unsigned AW = dwsb_pkg::ACC_BITS;

  logic [CB-1:0]        dl, dr, tgt_ext, bthr_ext, mag;
  logic signed [CB:0]   e, neg_e, thr_s;
  logic [CW-1:0]        corr;
  logic signed [AW-1:0] corr_s, half_s, step_s, boost_s, duty_max_s;
  logic signed [AW-1:0] l_acc, r_acc;
  logic                 over, pos_hit, neg_hit, idle;

  // modular count deltas and wheel difference
  assign dl       = left_count_i - last_left_i;
  assign dr       = right_count_i - last_right_i;
  assign tgt_ext  = CB'(cfg_i.target_count);
  assign bthr_ext = CB'(cfg_i.boost_threshold);
  assign e        = $signed({1'b0, dl}) - $signed({1'b0, dr});
  assign neg_e    = -e;
  assign mag      = e[CB] ? neg_e[CB-1:0] : e[CB-1:0];
  assign thr_s    = $signed((CB+1)'(cfg_i.diff_threshold));
  assign pos_hit  = (e >= thr_s);
  assign neg_hit  = (neg_e >= thr_s);

  // gain-scaled correction
  assign corr       = CW'(mag) * CW'(cfg_i.balance_gain);
  assign corr_s     = $signed(AW'(corr));
  assign half_s     = $signed(AW'(corr >> 1));
  assign step_s     = $signed(AW'(cfg_i.pwm_step));
  assign boost_s    = $signed(AW'(cfg_i.boost_amount));
  assign duty_max_s = $signed(AW'({DB{1'b1}}));
  assign idle       = (dl == '0) && (dr == '0) && (cfg_i.target_count == '0);

  // accumulate both duties in wide signed form
  always_comb begin
    l_acc = $signed(AW'(left_duty_i));
    r_acc = $signed(AW'(right_duty_i));
    over  = 1'b0;
    if (dl < tgt_ext) begin
      l_acc = l_acc + step_s;
    end else if (dl > tgt_ext) begin
      l_acc = l_acc - step_s;
      over  = 1'b1;
    end
    if (dr < tgt_ext) begin
      r_acc = r_acc + step_s;
    end else if (dr > tgt_ext) begin
      r_acc = r_acc - step_s;
      over  = 1'b1;
    end
    // high speed boost on the left wheel
    if ((dl >= bthr_ext) && (cfg_i.target_count > cfg_i.boost_threshold)) begin
      l_acc = l_acc + boost_s;
    end
    // balancing: help the slow wheel, or on overshoot also cut the fast one
    if (!over) begin
      if (pos_hit) begin
        r_acc = r_acc + corr_s;
      end
      if (neg_hit) begin
        l_acc = l_acc + corr_s;
      end
    end else begin
      if (pos_hit) begin
        l_acc = l_acc - corr_s;
        r_acc = r_acc + half_s;
      end
      if (neg_hit) begin
        r_acc = r_acc - corr_s;
        l_acc = l_acc + half_s;
      end
    end
  end

  // saturation and idle override
  always_comb begin
    if (l_acc < 0) begin
      res_o.left_duty = '0;
    end else if (l_acc > duty_max_s) begin
      res_o.left_duty = {DB{1'b1}};
    end else begin
      res_o.left_duty = l_acc[DB-1:0];
    end
    if (r_acc < 0) begin
      res_o.right_duty = '0;
    end else if (r_acc > duty_max_s) begin
      res_o.right_duty = {DB{1'b1}};
    end else begin
      res_o.right_duty = r_acc[DB-1:0];
    end
    res_o.idle_forced = idle;
    if (idle) begin
      res_o.left_duty  = DB'(1);
      res_o.right_duty = DB'(1);
    end
  end

endmodule

// ----- hw/rtl/dual_wheel_speed_balancer_top.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_speed_balancer_top
// A result passes through the input register and then the result register
// before it is valid on the output channel.
// Throughput: one beat per cycle while the output is not stalled; the stored
// duties and counts update as an item moves from input to result register.
// Reset: stored counts and duties clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
module dual_wheel_speed_balancer_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dwsb_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [dwsb_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  dwsb_in_if.sink                               in_i,
  dwsb_out_if.source                            out_o
);

  localparam int unsigned CB = dwsb_pkg::COUNT_BITS;
  localparam int unsigned DB = dwsb_pkg::DUTY_BITS;

  dwsb_pkg::cfg_t  cfg_q;
  dwsb_pkg::res_t  res_d, res_q;
  logic [CB-1:0]   lc_q, rc_q, last_l_q, last_r_q;
  logic [DB-1:0]   left_q, right_q;
  logic            v1_q, v2_q;
  logic            in_fire, advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_count    <= dwsb_pkg::TargetCountRst;
      cfg_q.pwm_step        <= dwsb_pkg::PwmStepRst;
      cfg_q.boost_amount    <= dwsb_pkg::BoostAmountRst;
      cfg_q.boost_threshold <= dwsb_pkg::BoostThresholdRst;
      cfg_q.diff_threshold  <= dwsb_pkg::DiffThresholdRst;
      cfg_q.balance_gain    <= dwsb_pkg::BalanceGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dwsb_pkg::CfgTargetCount:    cfg_q.target_count    <= cfg_wdata_i;
        dwsb_pkg::CfgPwmStep:        cfg_q.pwm_step        <= cfg_wdata_i[3:0];
        dwsb_pkg::CfgBoostAmount:    cfg_q.boost_amount    <= cfg_wdata_i[3:0];
        dwsb_pkg::CfgBoostThreshold: cfg_q.boost_threshold <= cfg_wdata_i;
        dwsb_pkg::CfgDiffThreshold:  cfg_q.diff_threshold  <= cfg_wdata_i;
        dwsb_pkg::CfgBalanceGain:    cfg_q.balance_gain    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // handshake between the two register stages
  assign advance    = v1_q && (!v2_q || out_o.ready);
  assign in_i.ready = !v1_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_i.ready) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lc_q <= in_i.left_count;
      rc_q <= in_i.right_count;
    end
  end

  // update step
  dwsb_core u_core (
    .cfg_i         (cfg_q),
    .left_count_i  (lc_q),
    .right_count_i (rc_q),
    .last_left_i   (last_l_q),
    .last_right_i  (last_r_q),
    .left_duty_i   (left_q),
    .right_duty_i  (right_q),
    .res_o         (res_d)
  );

  // stored counts and duties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      left_q   <= '0;
      right_q  <= '0;
    end else if (advance) begin
      last_l_q <= lc_q;
      last_r_q <= rc_q;
      left_q   <= res_d.left_duty;
      right_q  <= res_d.right_duty;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance) begin
      v2_q <= 1'b1;
    end else if (out_o.ready) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = v2_q;
  assign out_o.left_duty   = res_q.left_duty;
  assign out_o.right_duty  = res_q.right_duty;
  assign out_o.idle_forced = res_q.idle_forced;

`ifndef SYNTH
  // idle rule always shows as both duties at one
  a_idle_duties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && res_q.idle_forced) |-> (res_q.left_duty == DB'(1) &&
                                     res_q.right_duty == DB'(1)))
    else $error("idle result without both duties at one");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // stored duties track the most recent result
  a_state_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (v2_q && left_q == res_q.left_duty && right_q == res_q.right_duty))
    else $error("stored duties differ from the issued result");

  // stored counts take the item that just moved on
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (last_l_q == $past(lc_q) && last_r_q == $past(rc_q)))
    else $error("stored counts not updated from the advancing item");
`endif

endmodule

// ----- test/dwsb_balance_checker.sv -----
// ----------------------------------------------------------------------------
// dwsb_balance_checker
// Watches the register port and both channels of the dual wheel speed
// balancer. Keeps its own copy of the registers, the previous counts and the
// stored duties, works out the duties each input beat should give, and
// compares every result beat field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module dwsb_balance_checker
  import dwsb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  dwsb_in_if                       in_mon_i,
  dwsb_out_if                      out_mon_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DutyTop = (longint'(1) << DUTY_BITS) - 1;
  localparam int unsigned ReportCap = 40;

  // mirrored registers and block state
  cfg_t                  regs;
  logic [COUNT_BITS-1:0] prev_left;
  logic [COUNT_BITS-1:0] prev_right;
  logic [DUTY_BITS-1:0]  left_duty_q;
  logic [DUTY_BITS-1:0]  right_duty_q;

  res_t        duty_expect_q[$];
  int unsigned fail_tally = 0;
  int unsigned beat_idx = 0;

  function automatic longint saturate_duty(input longint v);
    if (v < 0) return 0;
    if (v > DutyTop) return DutyTop;
    return v;
  endfunction

  // one update interval: new duties from the count deltas, state advances
  function automatic res_t next_duties(input logic [COUNT_BITS-1:0] lc,
                                       input logic [COUNT_BITS-1:0] rc);
    logic [COUNT_BITS-1:0] dl_w;
    logic [COUNT_BITS-1:0] dr_w;
    longint dl, dr, tgt, step, boost, bthr, thr, gain;
    longint lft, rgt, e, mag, c;
    bit     over;
    res_t   r;
    dl_w  = lc - prev_left;
    dr_w  = rc - prev_right;
    dl    = longint'(dl_w);
    dr    = longint'(dr_w);
    tgt   = longint'(regs.target_count);
    step  = longint'(regs.pwm_step);
    boost = longint'(regs.boost_amount);
    bthr  = longint'(regs.boost_threshold);
    thr   = longint'(regs.diff_threshold);
    gain  = longint'(regs.balance_gain);
    lft   = longint'(left_duty_q);
    rgt   = longint'(right_duty_q);
    over  = 1'b0;

    // per wheel step toward the target rate
    if (dl < tgt) begin
      lft = lft + step;
    end else if (dl > tgt) begin
      lft  = lft - step;
      over = 1'b1;
    end
    if (dr < tgt) begin
      rgt = rgt + step;
    end else if (dr > tgt) begin
      rgt  = rgt - step;
      over = 1'b1;
    end

    // high speed boost on the left wheel
    if (dl >= bthr && tgt > bthr) lft = lft + boost;

    // balancing correction, half of it to the slower wheel on overshoot
    e   = dl - dr;
    mag = (e < 0) ? -e : e;
    c   = gain * mag;
    if (!over) begin
      if (e >= thr) rgt = rgt + c;
      if (-e >= thr) lft = lft + c;
    end else begin
      if (e >= thr) begin
        lft = lft - c;
        rgt = rgt + (c >> 1);
      end
      if (-e >= thr) begin
        rgt = rgt - c;
        lft = lft + (c >> 1);
      end
    end

    lft = saturate_duty(lft);
    rgt = saturate_duty(rgt);

    // idle rule: no motion at zero target
    r.idle_forced = 1'b0;
    if (dl == 0 && dr == 0 && tgt == 0) begin
      lft = 1;
      rgt = 1;
      r.idle_forced = 1'b1;
    end

    r.left_duty  = lft[DUTY_BITS-1:0];
    r.right_duty = rgt[DUTY_BITS-1:0];
    prev_left    = lc;
    prev_right   = rc;
    left_duty_q  = r.left_duty;
    right_duty_q = r.right_duty;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DUTY_BITS-1:0] got,
                               input logic [DUTY_BITS-1:0] want);
    fail_tally++;
    if (fail_tally <= ReportCap) begin
      $display("mismatch on result beat %0d: %s got %0d expected %0d",
               beat_idx, what, got, want);
    end
  endtask

  // track registers, predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      regs = '{target_count:    TargetCountRst,
               pwm_step:        PwmStepRst,
               boost_amount:    BoostAmountRst,
               boost_threshold: BoostThresholdRst,
               diff_threshold:  DiffThresholdRst,
               balance_gain:    BalanceGainRst};
      prev_left    = '0;
      prev_right   = '0;
      left_duty_q  = '0;
      right_duty_q = '0;
      duty_expect_q.delete();
      pending_o    <= 0;
      fail_count_o <= fail_tally;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTargetCount:    regs.target_count    = cfg_wdata_i[TGT_BITS-1:0];
          CfgPwmStep:        regs.pwm_step        = cfg_wdata_i[STEP_BITS-1:0];
          CfgBoostAmount:    regs.boost_amount    = cfg_wdata_i[STEP_BITS-1:0];
          CfgBoostThreshold: regs.boost_threshold = cfg_wdata_i[TGT_BITS-1:0];
          CfgDiffThreshold:  regs.diff_threshold  = cfg_wdata_i[TGT_BITS-1:0];
          CfgBalanceGain:    regs.balance_gain    = cfg_wdata_i[GAIN_BITS-1:0];
          default: ;
        endcase
      end

      if (out_mon_i.valid && out_mon_i.ready) begin
        beat_idx++;
        if (duty_expect_q.size() == 0) begin
          flag_mismatch("beat with nothing waiting, left_duty", out_mon_i.left_duty, '0);
        end else begin
          want = duty_expect_q.pop_front();
          if (out_mon_i.left_duty !== want.left_duty)
            flag_mismatch("left_duty", out_mon_i.left_duty, want.left_duty);
          if (out_mon_i.right_duty !== want.right_duty)
            flag_mismatch("right_duty", out_mon_i.right_duty, want.right_duty);
          if (out_mon_i.idle_forced !== want.idle_forced)
            flag_mismatch("idle_forced", DUTY_BITS'(out_mon_i.idle_forced),
                          DUTY_BITS'(want.idle_forced));
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        duty_expect_q.push_back(next_duties(in_mon_i.left_count, in_mon_i.right_count));
      end

      pending_o    <= duty_expect_q.size();
      fail_count_o <= fail_tally;
    end
  end

endmodule

// ----- test/dual_wheel_speed_balancer_top_tb.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_speed_balancer_top_tb
// Drives encoder count beats and register writes into the balancer, with
// random gaps on the sender and random stalls plus one long hold-off on the
// receiver. A short directed run covers the corner cases, then random phases
// each pick new register settings. The checker beside the block does the
// prediction and comparison; this module only gives the verdict.
// ----------------------------------------------------------------------------
module dual_wheel_speed_balancer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dwsb_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseItems    = 250;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned QuietPhase    = 3;
  localparam int unsigned HoldPhase     = 1;
  localparam logic [CFG_IDX_BITS-1:0] CfgSpareIdxA = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CfgSpareIdxB = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending;

  bit          idling_on   = 1'b1;
  bit          hold_off_go = 1'b0;
  int unsigned hold_left;
  int unsigned cycles;

  logic [COUNT_BITS-1:0] sent_left;
  logic [COUNT_BITS-1:0] sent_right;
  int                    cur_target;

  dwsb_in_if  in_if ();
  dwsb_out_if out_if ();

  dual_wheel_speed_balancer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  dwsb_balance_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one count beat, held until accepted, with an occasional gap before it
  task automatic push_counts(input logic [COUNT_BITS-1:0] lc,
                             input logic [COUNT_BITS-1:0] rc);
    while (idling_on && $urandom_range(0, 99) < 7) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.left_count  <= lc;
    in_if.right_count <= rc;
    sent_left  = lc;
    sent_right = rc;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic push_delta(input logic [COUNT_BITS-1:0] dl,
                            input logic [COUNT_BITS-1:0] dr);
    push_counts(sent_left + dl, sent_right + dr);
  endtask

  // wait until every beat in flight has come out
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // full register set, written only once the block is empty
  task automatic apply_settings(input logic [7:0] tgt, input logic [7:0] step,
                                input logic [7:0] boost, input logic [7:0] bthr,
                                input logic [7:0] dthr, input logic [7:0] gain);
    settle();
    put_reg(CfgTargetCount, tgt);
    put_reg(CfgPwmStep, step);
    put_reg(CfgBoostAmount, boost);
    put_reg(CfgBoostThreshold, bthr);
    put_reg(CfgDiffThreshold, dthr);
    put_reg(CfgBalanceGain, gain);
    put_reg($urandom_range(0, 1) ? CfgSpareIdxA : CfgSpareIdxB, 8'($urandom));
    cfg_we_i   <= 1'b0;
    cur_target = int'(tgt);
  endtask

  // register value, often at an extreme; narrow ones get junk upper bits
  function automatic logic [7:0] rand_reg(input bit narrow);
    case ($urandom_range(0, 4))
      0:       return narrow ? {4'($urandom), 4'h0} : 8'h00;
      1:       return narrow ? {4'($urandom), 4'hF} : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left   = HoldOffCycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idling_on && $urandom_range(0, 99) < 7);
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned k;
    int          dl, dr, jit;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgTargetCount;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.left_count  <= '0;
    in_if.right_count <= '0;
    sent_left  = '0;
    sent_right = '0;
    cur_target = int'(TargetCountRst);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // reset settings: idle rule, then motion at zero target
    push_delta(0, 0);
    push_delta(0, 3);

    // mid target, max step and gain, upper bits set on the narrow registers
    apply_settings(8'd20, 8'hAF, 8'h3F, 8'd10, 8'd1, 8'h9F);
    push_delta(30, 10);
    push_delta(5, 4);
    push_delta(12, 12);
    push_delta(25, 22);
    push_delta(20, 20);
    push_counts(32'hFFFF_FFF0, 32'hFFFF_FFF8);
    // counters wrap, then run backwards
    push_counts(32'd4, 32'd2);
    push_counts(32'd0, 32'd0);
    push_counts('1, '1);
    push_counts('1, '0);
    push_counts(32'h5555_5555, 32'hAAAA_AAAA);

    // top target, everything else zero, zero diff threshold
    apply_settings(8'd255, 8'h00, 8'hF0, 8'd0, 8'd0, 8'h00);
    push_delta(7, 7);
    push_delta(0, 9);
    push_delta(255, 0);

    // boost right at its threshold
    apply_settings(8'd255, 8'hF5, 8'hFF, 8'd254, 8'd255, 8'h13);
    push_delta(254, 250);
    push_delta(300, 45);

    // zero target with the widest diff threshold
    apply_settings(8'd0, 8'h01, 8'h01, 8'd255, 8'd255, 8'hFF);
    push_delta(0, 0);
    push_delta(1, 0);
    push_delta(600, 0);

    // random phases
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      apply_settings(rand_reg(1'b0), rand_reg(1'b1), rand_reg(1'b1),
                     rand_reg(1'b0), rand_reg(1'b0), rand_reg(1'b1));
      idling_on = (p != QuietPhase);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (p == HoldPhase && n == 40) hold_off_go = 1'b1;
        k = $urandom_range(0, 99);
        if (k < 70) begin
          // deltas close to the target rate
          jit = $urandom_range(0, 16);
          dl  = cur_target + jit - 8;
          if (dl < 0) dl = 0;
          jit = $urandom_range(0, 16);
          dr  = cur_target + jit - 8;
          if (dr < 0) dr = 0;
          push_delta(dl, dr);
        end else if (k < 80) begin
          push_delta($urandom_range(0, 3), $urandom_range(0, 3));
        end else if (k < 92) begin
          push_counts($urandom, $urandom);
        end else begin
          jit = $urandom_range(1, 5);
          push_delta(-jit, $urandom_range(0, 600));
        end
      end
    end
    idling_on = 1'b1;

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
